@@ rtl/egt_pkg.sv @@
// ---------------------------------------------------------------------------
// egt_pkg - elevation grant table shared definitions
// Entry layout, operation and status codes, port payload layouts.
// ---------------------------------------------------------------------------
package egt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int PID_W   = 16;
    localparam int UID_W   = 16;
    localparam int RSN_W   = 3;
    localparam int NOW_W   = 48;
    localparam int EXP_W   = 49;
    localparam int TMO_W   = 32;
    localparam int TALLY_W = 5;   // pending_total / expired_count field width

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 56;
    localparam int IN_PAD_W   = 7;
    localparam int OUT_PAD_W  = 3;

    // configuration register indexes
    localparam logic [0:0] CFG_ENABLE  = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT = 1'b1;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd300000;

    typedef enum logic [2:0] {
        KIND_REQUEST     = 3'd0,
        KIND_GRANT       = 3'd1,
        KIND_DENY        = 3'd2,
        KIND_DROP        = 3'd3,
        KIND_TICK        = 3'd4,
        KIND_QUERY       = 3'd5,
        KIND_PEND_COUNT  = 3'd6,
        KIND_PEND_INDEX  = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        SLOT_NONE     = 3'd0,
        SLOT_PENDING  = 3'd1,
        SLOT_ELEVATED = 3'd2,
        SLOT_DENIED   = 3'd3,
        SLOT_EXPIRED  = 3'd4
    } slot_status_t;

    typedef enum logic [1:0] {
        REQ_FAILED  = 2'd0,
        REQ_ALLOWED = 2'd1,
        REQ_PENDING = 2'd2
    } req_status_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [UID_W-1:0] uid;
        logic [RSN_W-1:0] reason;
        slot_status_t     status;
        logic [EXP_W-1:0] expiry;
    } slot_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        slot_t            data;
    } mem_wr_t;

    // request fields, last member sits in the lowest bits
    typedef struct packed {
        logic [IN_PAD_W-1:0] pad;
        logic [3:0]          pending_index;
        logic [NOW_W-1:0]    now_ms;
        logic                uid_is_admin;
        logic [UID_W-1:0]    proc_uid;
        logic                proc_found;
        logic [RSN_W-1:0]    reason;
        logic [PID_W-1:0]    pid;
    } in_item_t;

    typedef struct packed {
        logic [TALLY_W-1:0] expired_count;
        logic [RSN_W-1:0]   entry_reason;
        logic [UID_W-1:0]   entry_uid;
        logic [PID_W-1:0]   entry_pid;
        logic               entry_found;
        logic [TALLY_W-1:0] pending_total;
        logic               is_elevated;
        logic [RSN_W-1:0]   notify_reason;
        logic               notify;
        req_status_t        request_status;
    } result_t;

endpackage

@@ rtl/egt_store.sv @@
// ---------------------------------------------------------------------------
// egt_store - entry memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module egt_store (
    input  logic                     clk,
    input  egt_pkg::mem_wr_t         wr,
    input  logic                     rd_en,
    input  logic [egt_pkg::IDX_W-1:0] rd_addr,
    output egt_pkg::slot_t           rd_data
);

    egt_pkg::slot_t mem [egt_pkg::ENTRIES];
    egt_pkg::slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/elevation_grant_table.sv @@
// ---------------------------------------------------------------------------
// elevation_grant_table - privilege elevation grant table
// Append-only table of elevation entries keyed by process id.
// ---------------------------------------------------------------------------
// One request at a time. Lookups, ticks and pending counts walk the entries
// in table order through a synchronous memory with one read and one write
// port, one entry read a cycle with the read pipelined against evaluation;
// a lookup stops at the first pid match, a pending-by-index search at the
// wanted entry. A walk reads at most the entries appended so far (the fill
// count, at most ENTRIES), and fewer when a lookup or search hits early;
// a request that fails on enable or process checks, or that comes from root,
// skips the walk. Tick write-backs go out during the walk; the
// single update for request, grant, deny and drop is written in the cycle
// after it. The result sits in an output register, so a finished result may
// wait on m_tready while the next request is already taken. The memory needs
// no clearing pass: only entries below the fill count are ever read.
// ---------------------------------------------------------------------------
module elevation_grant_table (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    // pid, reason, proc_found, proc_uid, uid_is_admin, now_ms, pending_index
    input  logic [95:0] s_tdata,
    // kind
    input  logic [2:0]  s_tuser,
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    // request_status, notify, notify_reason, is_elevated, pending_total,
    // entry_found, entry_pid, entry_uid, entry_reason, expired_count
    output logic [55:0] m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic                          enable_reg;
    logic [egt_pkg::TMO_W-1:0]     timeout_reg;
    logic [egt_pkg::CNT_W-1:0]     fill_reg, fill_next;

    egt_pkg::in_item_t             in_reg, in_next, s_item;
    egt_pkg::kind_t                kind_reg, kind_next, s_kind;

    // walk control
    logic [egt_pkg::CNT_W-1:0]     ptr_reg, ptr_next;
    logic                          inflight_reg, inflight_next;
    logic [egt_pkg::IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic                          hit_reg, hit_next;
    logic [egt_pkg::IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    egt_pkg::slot_t                hit_word_reg, hit_word_next;
    logic [egt_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    egt_pkg::result_t              res_reg, res_next;
    logic                          out_valid_reg, out_valid_next;
    egt_pkg::result_t              out_data_reg, out_data_next;

    egt_pkg::mem_wr_t              mem_wr;
    logic                          rd_en;
    logic [egt_pkg::IDX_W-1:0]     rd_addr;
    egt_pkg::slot_t                rd_word;

    logic                          hit_now;
    logic                          scan_done;
    logic [egt_pkg::EXP_W-1:0]     grant_expiry;

    egt_store u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign s_item   = egt_pkg::in_item_t'(s_tdata);
    assign s_kind   = egt_pkg::kind_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{egt_pkg::OUT_PAD_W{1'b0}}, out_data_reg};

    // 48-bit time plus 32-bit timeout never exceeds the 49-bit expiry store,
    // so the sum never overflows
    assign grant_expiry = {1'b0, in_reg.now_ms} + egt_pkg::EXP_W'(timeout_reg);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            timeout_reg <= egt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                egt_pkg::CFG_ENABLE:  enable_reg  <= cfg_wdata[0];
                egt_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        in_next        = in_reg;
        kind_next      = kind_reg;
        ptr_next       = ptr_reg;
        inflight_next  = 1'b0;
        eval_idx_next  = eval_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_word_next  = hit_word_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;
        mem_wr         = '0;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[egt_pkg::IDX_W-1:0];
        hit_now        = 1'b0;
        scan_done      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_next   = s_item;
                    kind_next = s_kind;
                    ptr_next  = '0;
                    hit_next  = 1'b0;
                    cnt_next  = '0;
                    // requests failing enable or process checks, or from root, need no walk
                    if (s_kind == egt_pkg::KIND_REQUEST &&
                        (!enable_reg || !s_item.proc_found || s_item.proc_uid == '0))
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (inflight_reg)
                begin
                    case (kind_reg)
                        egt_pkg::KIND_TICK:
                        begin
                            if (rd_word.status == egt_pkg::SLOT_ELEVATED &&
                                {1'b0, in_reg.now_ms} >= rd_word.expiry)
                            begin
                                mem_wr.we          = 1'b1;
                                mem_wr.addr        = eval_idx_reg;
                                mem_wr.data        = rd_word;
                                mem_wr.data.status = egt_pkg::SLOT_EXPIRED;
                                cnt_next           = cnt_reg + egt_pkg::CNT_W'(1);
                            end
                        end
                        egt_pkg::KIND_PEND_COUNT:
                        begin
                            if (rd_word.status == egt_pkg::SLOT_PENDING)
                            begin
                                cnt_next = cnt_reg + egt_pkg::CNT_W'(1);
                            end
                        end
                        egt_pkg::KIND_PEND_INDEX:
                        begin
                            if (rd_word.status == egt_pkg::SLOT_PENDING)
                            begin
                                if (cnt_reg == egt_pkg::CNT_W'(in_reg.pending_index))
                                begin
                                    hit_now = 1'b1;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + egt_pkg::CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // pid lookup, first match wins
                            hit_now = (rd_word.pid == in_reg.pid);
                        end
                    endcase
                    if (hit_now)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = eval_idx_reg;
                        hit_word_next = rd_word;
                    end
                end

                scan_done = hit_now || (ptr_reg >= fill_reg);
                if (scan_done)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    rd_en         = 1'b1;
                    ptr_next      = ptr_reg + egt_pkg::CNT_W'(1);
                    inflight_next = 1'b1;
                    eval_idx_next = ptr_reg[egt_pkg::IDX_W-1:0];
                end
            end

            S_UPDATE:
            begin
                res_next   = '0;
                state_next = S_DONE;
                case (kind_reg)
                    egt_pkg::KIND_REQUEST:
                    begin
                        if (!enable_reg || !in_reg.proc_found)
                        begin
                            res_next.request_status = egt_pkg::REQ_FAILED;
                        end
                        else if (in_reg.proc_uid == '0)
                        begin
                            res_next.request_status = egt_pkg::REQ_ALLOWED;
                        end
                        else if (hit_reg && hit_word_reg.status == egt_pkg::SLOT_ELEVATED)
                        begin
                            res_next.request_status = egt_pkg::REQ_ALLOWED;
                        end
                        else if (!in_reg.uid_is_admin ||
                                 fill_reg >= egt_pkg::CNT_W'(egt_pkg::ENTRIES))
                        begin
                            res_next.request_status = egt_pkg::REQ_FAILED;
                        end
                        else
                        begin
                            mem_wr.we          = 1'b1;
                            mem_wr.addr        = hit_reg ? hit_idx_reg
                                                         : fill_reg[egt_pkg::IDX_W-1:0];
                            mem_wr.data.pid    = in_reg.pid;
                            mem_wr.data.uid    = in_reg.proc_uid;
                            mem_wr.data.reason = in_reg.reason;
                            mem_wr.data.status = egt_pkg::SLOT_PENDING;
                            mem_wr.data.expiry = '0;
                            if (!hit_reg)
                            begin
                                fill_next = fill_reg + egt_pkg::CNT_W'(1);
                            end
                            res_next.request_status = egt_pkg::REQ_PENDING;
                            res_next.notify         = 1'b1;
                            res_next.notify_reason  = in_reg.reason;
                        end
                    end
                    egt_pkg::KIND_GRANT:
                    begin
                        if (hit_reg && hit_word_reg.status == egt_pkg::SLOT_PENDING)
                        begin
                            mem_wr.we          = 1'b1;
                            mem_wr.addr        = hit_idx_reg;
                            mem_wr.data        = hit_word_reg;
                            mem_wr.data.status = egt_pkg::SLOT_ELEVATED;
                            mem_wr.data.expiry = grant_expiry;
                        end
                    end
                    egt_pkg::KIND_DENY:
                    begin
                        if (hit_reg && hit_word_reg.status == egt_pkg::SLOT_PENDING)
                        begin
                            mem_wr.we          = 1'b1;
                            mem_wr.addr        = hit_idx_reg;
                            mem_wr.data        = hit_word_reg;
                            mem_wr.data.status = egt_pkg::SLOT_DENIED;
                        end
                    end
                    egt_pkg::KIND_DROP:
                    begin
                        if (hit_reg)
                        begin
                            mem_wr.we          = 1'b1;
                            mem_wr.addr        = hit_idx_reg;
                            mem_wr.data        = hit_word_reg;
                            mem_wr.data.status = egt_pkg::SLOT_NONE;
                        end
                    end
                    egt_pkg::KIND_TICK:
                    begin
                        res_next.expired_count = egt_pkg::TALLY_W'(cnt_reg);
                    end
                    egt_pkg::KIND_QUERY:
                    begin
                        res_next.is_elevated =
                            hit_reg && hit_word_reg.status == egt_pkg::SLOT_ELEVATED;
                    end
                    egt_pkg::KIND_PEND_COUNT:
                    begin
                        res_next.pending_total = egt_pkg::TALLY_W'(cnt_reg);
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            res_next.entry_found  = 1'b1;
                            res_next.entry_pid    = hit_word_reg.pid;
                            res_next.entry_uid    = hit_word_reg.uid;
                            res_next.entry_reason = hit_word_reg.reason;
                        end
                    end
                endcase
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            inflight_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            inflight_reg  <= inflight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        kind_reg     <= kind_next;
        ptr_reg      <= ptr_next;
        eval_idx_reg <= eval_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_word_reg <= hit_word_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // table never grows past its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= egt_pkg::CNT_W'(egt_pkg::ENTRIES))
        else $error("fill count beyond table depth");

    // walk reads stay below the fill count
    a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (ptr_reg < fill_reg))
        else $error("read of an entry never appended");

    // memory writes only from tick walk or the update step
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.we |-> ((state_reg == S_SCAN && kind_reg == egt_pkg::KIND_TICK) ||
                       state_reg == S_UPDATE))
        else $error("entry write outside tick walk or update");

    // a new result only follows the done step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !m_tready) && $changed(out_data_reg))
            |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done step");
`endif

endmodule
